FILE: src/linked_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// linked_block_allocator_macros.svh
// assertion macros shared by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef LINKED_BLOCK_ALLOCATOR_MACROS_SVH
`define LINKED_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define LBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/lba_pkg.sv
// ----------------------------------------------------------------------------
// lba_pkg
// shared sizes, codes and types of the linked block allocator
// ----------------------------------------------------------------------------
package lba_pkg;

   localparam int BLOCKS     = 1024;
   localparam int FILES      = 128;
   localparam int IDX_W      = $clog2(BLOCKS);
   localparam int BLK_W      = IDX_W + 1;
   localparam int FIDX_W     = $clog2(FILES);
   localparam int CNT_W      = $clog2(FILES + 1);
   localparam int TAG_W      = 32;
   localparam int BYTES_W    = 24;
   localparam int BPB_W      = 16;
   localparam int TBU_W      = 11;
   localparam int STATUS_W   = 3;
   localparam int OUT_W      = 11;
   localparam int DVD_W      = BYTES_W + 1;
   localparam int DVS_W      = BPB_W;
   localparam int DIV_CNT_W  = $clog2(DVD_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int LFSR_W     = 16;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   localparam logic [TBU_W-1:0] TBU_RESET = 11'd1024;
   localparam logic [BPB_W-1:0] BPB_RESET = 16'd512;

   localparam logic ACT_CREATE = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BLOCKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES  = 1'd1;

   localparam logic [STATUS_W-1:0] ST_CREATED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
      logic [LFSR_W-1:0] sh;
      sh = s >> 1;
      return s[0] ? (sh ^ LFSR_TAPS) : sh;
   endfunction

endpackage

FILE: src/lba_req_if.sv
// ----------------------------------------------------------------------------
// lba_req_if
// request channel: one word per file operation
// ----------------------------------------------------------------------------
interface lba_req_if import lba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [TAG_W-1:0]   file_tag;
   logic [BYTES_W-1:0] file_bytes;

   modport source (output valid, action, file_tag, file_bytes, input ready);
   modport sink   (input valid, action, file_tag, file_bytes, output ready);
endinterface

FILE: src/lba_rsp_if.sv
// ----------------------------------------------------------------------------
// lba_rsp_if
// response channel: one word per file operation
// ----------------------------------------------------------------------------
interface lba_rsp_if import lba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OUT_W-1:0]    first_block;
   logic [OUT_W-1:0]    block_total;

   modport source (output valid, status, first_block, block_total, input ready);
   modport sink   (input valid, status, first_block, block_total, output ready);
endinterface

FILE: src/lba_csr_if.sv
// ----------------------------------------------------------------------------
// lba_csr_if
// register write channel
// ----------------------------------------------------------------------------
interface lba_csr_if import lba_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: src/lba_div.sv
// ----------------------------------------------------------------------------
// lba_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lba_div import lba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       diff;
   logic                 ge;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = cmd.dividend;
         dvs_in  = cmd.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;

endmodule

FILE: src/linked_block_allocator.sv
// ----------------------------------------------------------------------------
// linked_block_allocator: linked-chain block allocator with a file table
// create: ceiling divide, then per block a random start, bitmap probes and a link;
// rollback frees the partial chain; delete searches, frees the chain, shifts entries
// one word at a time; the divider is bit-serial and the scan probes one entry at a time
// reset: bitmap clearing pass over every block, req not ready meanwhile, csr taken
// ----------------------------------------------------------------------------
`include "linked_block_allocator_macros.svh"

module linked_block_allocator import lba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lba_req_if.sink   req_chan,
   lba_rsp_if.source rsp_chan,
   lba_csr_if.sink   csr_chan
);

   // sequencer states
   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DIV_NEED  = 4'd2;
   localparam logic [3:0] S_LOOP      = 4'd3;
   localparam logic [3:0] S_DIV_START = 4'd4;
   localparam logic [3:0] S_PROBE_RD  = 4'd5;
   localparam logic [3:0] S_PROBE_CHK = 4'd6;
   localparam logic [3:0] S_LINK      = 4'd7;
   localparam logic [3:0] S_FREE_RD   = 4'd8;
   localparam logic [3:0] S_FREE_CHK  = 4'd9;
   localparam logic [3:0] S_SRCH_RD   = 4'd10;
   localparam logic [3:0] S_SRCH_CHK  = 4'd11;
   localparam logic [3:0] S_SHIFT_RD  = 4'd12;
   localparam logic [3:0] S_SHIFT_WR  = 4'd13;
   localparam logic [3:0] S_DONE      = 4'd14;

   localparam logic [BLK_W-1:0] BLK_NULL = BLK_W'(BLOCKS);

   // storage
   logic             used_mem [BLOCKS];
   logic [BLK_W-1:0] link_mem [BLOCKS];
   logic [TAG_W-1:0] tag_mem  [FILES];
   logic [BLK_W-1:0] head_mem [FILES];

   // control and datapath registers
   logic [3:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic                action_ff, action_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [DVD_W-1:0]    need_ff, need_in;
   logic [BLK_W-1:0]    taken_ff, taken_in;
   logic [BLK_W-1:0]    head_ff, head_in;
   logic [BLK_W-1:0]    tail_ff, tail_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [BLK_W-1:0]    scan_ff, scan_in;
   logic [BLK_W-1:0]    cur_ff, cur_in;
   logic [BLK_W-1:0]    fcnt_ff, fcnt_in;
   logic [FIDX_W-1:0]   fidx_ff, fidx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [BLK_W-1:0]    res_first_ff, res_first_in;
   logic [BLK_W-1:0]    res_total_ff, res_total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OUT_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [OUT_W-1:0]    rsp_total_ff, rsp_total_in;
   logic [TBU_W-1:0]    tbu_ff;
   logic [BPB_W-1:0]    bpb_ff;

   // registered memory read data
   logic             used_rd_ff;
   logic [BLK_W-1:0] link_rd_ff;
   logic [TAG_W-1:0] tag_rd_ff;
   logic [BLK_W-1:0] head_rd_ff;

   // memory write ports
   logic              used_we, used_wd;
   logic [IDX_W-1:0]  used_wa;
   logic              link_we;
   logic [IDX_W-1:0]  link_wa;
   logic [BLK_W-1:0]  link_wd;
   logic              ent_we;
   logic [FIDX_W-1:0] ent_wa;
   logic [TAG_W-1:0]  ent_tag_wd;
   logic [BLK_W-1:0]  ent_head_wd;

   // shared divider
   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic               req_fire;
   logic               rsp_free;
   logic [BLK_W-1:0]   eff_blocks;
   logic [BPB_W-1:0]   bpb_eff;
   logic [LFSR_W-1:0]  lfsr_step;
   logic [IDX_W-1:0]   idx_wrap;
   logic               fidx_last;

   lba_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   // block count register saturates at the built size
   assign eff_blocks = (32'(tbu_ff) > BLOCKS) ? BLK_NULL : BLK_W'(tbu_ff);
   // zero block size behaves as one byte
   assign bpb_eff    = (bpb_ff == '0) ? BPB_W'(1) : bpb_ff;
   assign lfsr_step  = lfsr_next(lfsr_ff);
   // circular scan wraps at the effective block count
   assign idx_wrap   = ((BLK_W'(idx_ff) + 1'b1) >= eff_blocks) ? '0 : idx_ff + 1'b1;
   assign fidx_last  = (CNT_W'(fidx_ff) + 1'b1) >= count_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      action_in     = action_ff;
      tag_in        = tag_ff;
      need_in       = need_ff;
      taken_in      = taken_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      idx_in        = idx_ff;
      scan_in       = scan_ff;
      cur_in        = cur_ff;
      fcnt_in       = fcnt_ff;
      fidx_in       = fidx_ff;
      count_in      = count_ff;
      lfsr_in       = lfsr_ff;
      res_status_in = res_status_ff;
      res_first_in  = res_first_ff;
      res_total_in  = res_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_total_in  = rsp_total_ff;

      used_we     = 1'b0;
      used_wa     = idx_ff;
      used_wd     = 1'b0;
      link_we     = 1'b0;
      link_wa     = idx_ff;
      link_wd     = BLK_NULL;
      ent_we      = 1'b0;
      ent_wa      = count_ff[FIDX_W-1:0];
      ent_tag_wd  = tag_ff;
      ent_head_wd = head_ff;

      div_cmd.start    = 1'b0;
      div_cmd.dividend = DVD_W'(req_chan.file_bytes) + DVD_W'(bpb_eff) - 1'b1;
      div_cmd.divisor  = bpb_eff;

      unique case (state_ff)
         S_CLEAR: begin
            used_we = 1'b1;
            used_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               action_in    = req_chan.action;
               tag_in       = req_chan.file_tag;
               res_first_in = BLK_NULL;
               res_total_in = '0;
               fidx_in      = '0;
               if (req_chan.action == ACT_DELETE) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_NOTFOUND;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end else if (count_ff == CNT_W'(FILES)) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  // ceiling of bytes over block size
                  div_cmd.start = 1'b1;
                  state_in      = S_DIV_NEED;
               end
            end
         end

         S_DIV_NEED: begin
            if (div_rsp.done) begin
               need_in  = div_rsp.quotient;
               taken_in = '0;
               head_in  = BLK_NULL;
               tail_in  = BLK_NULL;
               state_in = S_LOOP;
            end
         end

         S_LOOP: begin
            if (DVD_W'(taken_ff) == need_ff) begin
               ent_we        = 1'b1;
               count_in      = count_ff + 1'b1;
               res_status_in = ST_CREATED;
               res_first_in  = head_ff;
               res_total_in  = need_ff[BLK_W-1:0];
               state_in      = S_DONE;
            end else begin
               lfsr_in = lfsr_step;
               if (eff_blocks == '0) begin
                  cur_in   = head_ff;
                  fcnt_in  = '0;
                  state_in = S_FREE_RD;
               end else begin
                  // random start: lfsr modulo the block count
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = DVD_W'(lfsr_step);
                  div_cmd.divisor  = DVS_W'(eff_blocks);
                  state_in         = S_DIV_START;
               end
            end
         end

         S_DIV_START: begin
            if (div_rsp.done) begin
               idx_in   = div_rsp.remainder[IDX_W-1:0];
               scan_in  = '0;
               state_in = S_PROBE_RD;
            end
         end

         S_PROBE_RD: begin
            state_in = S_PROBE_CHK;
         end

         S_PROBE_CHK: begin
            if (!used_rd_ff) begin
               used_we = 1'b1;
               used_wd = 1'b1;
               link_we = 1'b1;
               if (head_ff == BLK_NULL) begin
                  head_in  = BLK_W'(idx_ff);
                  tail_in  = BLK_W'(idx_ff);
                  taken_in = taken_ff + 1'b1;
                  state_in = S_LOOP;
               end else begin
                  state_in = S_LINK;
               end
            end else if (scan_ff + 1'b1 == eff_blocks) begin
               // no free block left: roll back the partial chain
               cur_in   = head_ff;
               fcnt_in  = '0;
               state_in = S_FREE_RD;
            end else begin
               scan_in  = scan_ff + 1'b1;
               idx_in   = idx_wrap;
               state_in = S_PROBE_RD;
            end
         end

         S_LINK: begin
            link_we  = 1'b1;
            link_wa  = tail_ff[IDX_W-1:0];
            link_wd  = BLK_W'(idx_ff);
            tail_in  = BLK_W'(idx_ff);
            taken_in = taken_ff + 1'b1;
            state_in = S_LOOP;
         end

         S_FREE_RD: begin
            if ((cur_ff < BLK_NULL) && (fcnt_ff < BLK_NULL)) begin
               used_we  = 1'b1;
               used_wa  = cur_ff[IDX_W-1:0];
               state_in = S_FREE_CHK;
            end else if (action_ff == ACT_CREATE) begin
               res_status_in = ST_NOSPACE;
               state_in      = S_DONE;
            end else begin
               res_total_in = fcnt_ff;
               if (fidx_last) begin
                  count_in      = count_ff - 1'b1;
                  res_status_in = ST_DELETED;
                  state_in      = S_DONE;
               end else begin
                  fidx_in  = fidx_ff + 1'b1;
                  state_in = S_SHIFT_RD;
               end
            end
         end

         S_FREE_CHK: begin
            cur_in   = link_rd_ff;
            fcnt_in  = fcnt_ff + 1'b1;
            state_in = S_FREE_RD;
         end

         S_SRCH_RD: begin
            state_in = S_SRCH_CHK;
         end

         S_SRCH_CHK: begin
            if (tag_rd_ff == tag_ff) begin
               res_first_in = head_rd_ff;
               cur_in       = head_rd_ff;
               fcnt_in      = '0;
               state_in     = S_FREE_RD;
            end else if (fidx_last) begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_DONE;
            end else begin
               fidx_in  = fidx_ff + 1'b1;
               state_in = S_SRCH_RD;
            end
         end

         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            // move entry down one place
            ent_we      = 1'b1;
            ent_wa      = fidx_ff - 1'b1;
            ent_tag_wd  = tag_rd_ff;
            ent_head_wd = head_rd_ff;
            if (fidx_last) begin
               count_in      = count_ff - 1'b1;
               res_status_in = ST_DELETED;
               state_in      = S_DONE;
            end else begin
               fidx_in  = fidx_ff + 1'b1;
               state_in = S_SHIFT_RD;
            end
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_first_in  = OUT_W'(res_first_ff);
               rsp_total_in  = OUT_W'(res_total_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tbu_ff <= TBU_RESET;
         bpb_ff <= BPB_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_TOTAL_BLOCKS: tbu_ff <= csr_chan.wdata[TBU_W-1:0];
            CSR_BLOCK_BYTES:  bpb_ff <= csr_chan.wdata[BPB_W-1:0];
            default:          tbu_ff <= tbu_ff;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      tag_ff        <= tag_in;
      need_ff       <= need_in;
      taken_ff      <= taken_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      idx_ff        <= idx_in;
      scan_ff       <= scan_in;
      cur_ff        <= cur_in;
      fcnt_ff       <= fcnt_in;
      fidx_ff       <= fidx_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
      res_total_ff  <= res_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // used-block bitmap
   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      used_rd_ff <= used_mem[idx_ff];
   end

   // next-block links
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[cur_ff[IDX_W-1:0]];
   end

   // file table
   always_ff @(posedge clock) begin
      if (ent_we) begin
         tag_mem[ent_wa]  <= ent_tag_wd;
         head_mem[ent_wa] <= ent_head_wd;
      end
      tag_rd_ff  <= tag_mem[fidx_ff];
      head_rd_ff <= head_mem[fidx_ff];
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.first_block = rsp_first_ff;
   assign rsp_chan.block_total = rsp_total_ff;

   // checks
   `LBA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE, "accepted word did not start work")
   `LBA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(FILES), "file count above table size")
   `LBA_ASSERT_NOW(a_div_owner, clock, reset, div_rsp.done, (state_ff == S_DIV_NEED) || (state_ff == S_DIV_START), "divider finished outside a wait state")
   `LBA_ASSERT_NOW(a_scan_bound, clock, reset, state_ff == S_PROBE_CHK, scan_ff < eff_blocks, "scan ran past the block count")

endmodule
